// ===== rtl/core/battery_temp_monitor_unit_assert.svh =====
// assertion macros for the battery and temperature monitor
// needs clk and rst_n in the scope of each use
`ifndef BATTERY_TEMP_MONITOR_UNIT_ASSERT_SVH
`define BATTERY_TEMP_MONITOR_UNIT_ASSERT_SVH

`ifndef SYNTH
`define BTM_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btm assertion failed");
`define BTM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btm assertion failed");
`else
`define BTM_ASSERT_IMPLIES(label, ante, cons)
`define BTM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/btm_pkg.sv =====
// shared types, constants and codes for the battery and temperature monitor
// no dependencies
package btm_pkg;

    localparam int WINDOW     = 16;
    localparam int ADC_BITS   = 10;
    localparam int SLOT_W     = $clog2(WINDOW);
    localparam int SUM_W      = ADC_BITS + $clog2(WINDOW + 1);
    localparam int TIME_W     = 32;
    localparam int HOLDOFF_W  = 16;
    localparam int THRESH_W   = 10;
    localparam int TOL_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd3;

    localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET   = 16'd100;
    localparam logic [THRESH_W-1:0]  LOW_RESET       = 10'd512;
    localparam logic [THRESH_W-1:0]  DEAD_RESET      = 10'd450;
    localparam logic [TOL_W-1:0]     TOLERANCE_RESET = 4'd0;

    localparam logic [1:0] CHG_UNPLUGGED = 2'd0;
    localparam logic [1:0] CHG_CHARGING  = 2'd1;
    localparam logic [1:0] CHG_COMPLETE  = 2'd2;

    localparam logic [1:0] WARN_OK   = 2'd0;
    localparam logic [1:0] WARN_LOW  = 2'd1;
    localparam logic [1:0] WARN_DEAD = 2'd2;

    typedef logic [ADC_BITS-1:0] adc_t;

    typedef struct packed {
        logic [9:0]  temp_sample;
        logic [9:0]  battery_sample;
        logic [1:0]  charger_status;
        logic [31:0] now_ms;
        logic        user_active;
    } in_item_t;

    typedef struct packed {
        logic [9:0] temp_average;
        logic [9:0] battery_average;
        logic       battery_stable;
        logic [1:0] warning_level;
        logic       hold_power_on;
        logic       power_off_pulse;
    } out_item_t;

    typedef struct packed {
        logic [HOLDOFF_W-1:0] holdoff_ms;
        logic [THRESH_W-1:0]  low_threshold;
        logic [THRESH_W-1:0]  dead_threshold;
        logic [TOL_W-1:0]     stable_tolerance;
    } cfg_t;

endpackage

// ===== rtl/core/btm_avg_ring.sv =====
// ring buffer moving average with running sum
// depends on btm_pkg
module btm_avg_ring (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  btm_pkg::adc_t sample,
    output btm_pkg::adc_t avg_cur,
    output btm_pkg::adc_t avg_new
);
    import btm_pkg::*;

    adc_t              ring_reg [WINDOW];
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;

    assign sum_next  = sum_reg - SUM_W'(ring_reg[slot_reg]) + SUM_W'(sample);
    assign slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
    assign avg_cur   = ADC_BITS'(sum_reg / WINDOW);
    assign avg_new   = ADC_BITS'(sum_next / WINDOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            slot_reg <= '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else if (push)
        begin
            sum_reg            <= sum_next;
            slot_reg           <= slot_next;
            ring_reg[slot_reg] <= sample;
        end
    end

endmodule

// ===== rtl/core/btm_monitor_core.sv =====
// battery stability, sample hold-off, warning and charger power logic
// depends on btm_pkg
module btm_monitor_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  btm_pkg::in_item_t  item,
    input  btm_pkg::cfg_t      cfg,
    input  btm_pkg::adc_t      temp_avg_new,
    input  btm_pkg::adc_t      bat_avg_cur,
    input  btm_pkg::adc_t      bat_avg_new,
    output logic               take,
    output btm_pkg::out_item_t result
);
    import btm_pkg::*;

    adc_t              prev_avg_reg;
    logic              prev_valid_reg;
    logic [TIME_W-1:0] last_time_reg;
    logic              was_charging_reg;
    logic              hold_reg;
    logic              hold_next;
    logic              was_charging_next;
    logic              pulse;
    logic              stable;
    logic              holdoff_done;
    adc_t              diff;
    adc_t              bat_avg;
    logic [TIME_W-1:0] elapsed;
    logic [1:0]        warn;

    assign diff         = (bat_avg_cur >= prev_avg_reg) ? bat_avg_cur - prev_avg_reg
                                                        : prev_avg_reg - bat_avg_cur;
    assign stable       = prev_valid_reg && (diff <= ADC_BITS'(cfg.stable_tolerance));
    assign elapsed      = item.now_ms - last_time_reg;
    assign holdoff_done = elapsed > TIME_W'(cfg.holdoff_ms);
    assign take         = !stable || holdoff_done;
    assign bat_avg      = take ? bat_avg_new : bat_avg_cur;

    always_comb
    begin
        hold_next         = hold_reg;
        was_charging_next = was_charging_reg;
        pulse             = 1'b0;
        unique case (item.charger_status)
            CHG_UNPLUGGED:
            begin
                if (!item.user_active && was_charging_reg)
                begin
                    pulse     = 1'b1;
                    hold_next = 1'b0;
                end
                was_charging_next = 1'b0;
            end
            CHG_CHARGING, CHG_COMPLETE:
            begin
                was_charging_next = 1'b1;
                hold_next         = 1'b1;
            end
            default:
            begin
                hold_next         = hold_reg;
                was_charging_next = was_charging_reg;
            end
        endcase
    end

    always_comb
    begin
        warn = WARN_OK;
        if (stable && item.charger_status == CHG_UNPLUGGED)
        begin
            priority if (bat_avg >= ADC_BITS'(cfg.low_threshold))
                warn = WARN_OK;
            else if (bat_avg >= ADC_BITS'(cfg.dead_threshold))
                warn = WARN_LOW;
            else
                warn = WARN_DEAD;
        end
    end

    assign result.temp_average    = 10'(temp_avg_new);
    assign result.battery_average = 10'(bat_avg);
    assign result.battery_stable  = stable;
    assign result.warning_level   = warn;
    assign result.hold_power_on   = hold_next;
    assign result.power_off_pulse = pulse;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg   <= 1'b0;
            last_time_reg    <= '0;
            was_charging_reg <= 1'b0;
            hold_reg         <= 1'b0;
        end
        else if (step)
        begin
            was_charging_reg <= was_charging_next;
            hold_reg         <= hold_next;
            if (take)
            begin
                prev_valid_reg <= 1'b1;
            end
            if (stable && holdoff_done)
            begin
                last_time_reg <= item.now_ms;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && take)
        begin
            prev_avg_reg <= bat_avg_cur;
        end
    end

endmodule

// ===== rtl/core/battery_temp_monitor_unit.sv =====
// an accepted item waits in the input register; its result is registered into
// the output register when the output advances, one transaction per cycle unless
// the output stalls; the sums, ring writes and decision logic update between them
// reset: asynchronous active low, clears both rings, sums, timers, charger state
// and loads the configuration defaults
`include "battery_temp_monitor_unit_assert.svh"

module battery_temp_monitor_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  btm_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output btm_pkg::out_item_t                  out_data,
    input  logic                                cfg_we,
    input  logic [btm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [btm_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import btm_pkg::*;

    cfg_t      cfg_reg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t out_data_reg;
    logic      out_valid_reg;
    out_item_t result;
    logic      advance;
    logic      step;
    logic      accept;
    logic      take;
    adc_t      temp_avg_cur;
    adc_t      temp_avg_new;
    adc_t      bat_avg_cur;
    adc_t      bat_avg_new;

    assign advance   = !out_valid_reg || out_ready;
    assign step      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.holdoff_ms       <= HOLDOFF_RESET;
            cfg_reg.low_threshold    <= LOW_RESET;
            cfg_reg.dead_threshold   <= DEAD_RESET;
            cfg_reg.stable_tolerance <= TOLERANCE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HOLDOFF:   cfg_reg.holdoff_ms       <= cfg_data[HOLDOFF_W-1:0];
                REG_LOW:       cfg_reg.low_threshold    <= cfg_data[THRESH_W-1:0];
                REG_DEAD:      cfg_reg.dead_threshold   <= cfg_data[THRESH_W-1:0];
                REG_TOLERANCE: cfg_reg.stable_tolerance <= cfg_data[TOL_W-1:0];
                default:       cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;
            if (step)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= in_data;
        if (step)
            out_data_reg <= result;
    end

    btm_avg_ring u_temp_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (step),
        .sample  (ADC_BITS'(in_item_reg.temp_sample)),
        .avg_cur (temp_avg_cur),
        .avg_new (temp_avg_new)
    );

    btm_avg_ring u_bat_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (step && take),
        .sample  (ADC_BITS'(in_item_reg.battery_sample)),
        .avg_cur (bat_avg_cur),
        .avg_new (bat_avg_new)
    );

    btm_monitor_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .item         (in_item_reg),
        .cfg          (cfg_reg),
        .temp_avg_new (temp_avg_new),
        .bat_avg_cur  (bat_avg_cur),
        .bat_avg_new  (bat_avg_new),
        .take         (take),
        .result       (result)
    );

    `BTM_ASSERT_NEXT(a_accept_loads, accept, in_valid_reg)
    `BTM_ASSERT_NEXT(a_step_gives_result, step, out_valid_reg)
    `BTM_ASSERT_NEXT(a_stalled_item_kept, in_valid_reg && !advance, in_valid_reg)
    `BTM_ASSERT_NEXT(a_result_held, out_valid_reg && !out_ready, out_valid_reg && $stable(out_data_reg))

endmodule

// ===== bench/battery_temp_monitor_checker.sv =====
// checker for the battery and temperature monitor: predicts each result and compares
// watches the input, result and register write ports; depends on btm_pkg
`timescale 1ns / 1ps

module battery_temp_monitor_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  btm_pkg::in_item_t              in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  btm_pkg::out_item_t             out_data,
    input  logic                           cfg_we,
    input  logic [btm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [btm_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatch_count,
    output int                             results_pending
);
    import btm_pkg::*;

    localparam int TEMP_CH    = 0;
    localparam int BATTERY_CH = 1;

    logic [HOLDOFF_W-1:0] holdoff_cfg;
    logic [THRESH_W-1:0]  low_cfg;
    logic [THRESH_W-1:0]  dead_cfg;
    logic [TOL_W-1:0]     tolerance_cfg;

    adc_t               ring [0:1][0:WINDOW-1];
    logic [SUM_W-1:0]   ring_sum [0:1];
    logic [SLOT_W-1:0]  ring_slot [0:1];
    adc_t               temp_avg;
    adc_t               battery_avg;
    adc_t               prior_battery_avg;
    logic               prior_valid;
    logic [TIME_W-1:0]  last_take_ms;
    logic               was_charging;
    logic               hold_on;

    out_item_t          expected_results[$];
    out_item_t          oldest;

    function automatic adc_t push_sample(input int ch, input adc_t sample);
        ring_sum[ch] = ring_sum[ch] - SUM_W'(ring[ch][ring_slot[ch]]) + SUM_W'(sample);
        ring[ch][ring_slot[ch]] = sample;
        if (int'(ring_slot[ch]) == WINDOW - 1)
            ring_slot[ch] = '0;
        else
            ring_slot[ch] = ring_slot[ch] + 1'b1;
        return adc_t'(ring_sum[ch] / WINDOW);
    endfunction

    function automatic out_item_t monitor_pass(input in_item_t item);
        out_item_t         res;
        int                diff;
        logic              stable;
        logic              take;
        logic [TIME_W-1:0] elapsed;
        res = '0;
        stable = 1'b0;
        take = 1'b0;
        temp_avg = push_sample(TEMP_CH, item.temp_sample);
        if (prior_valid)
        begin
            diff = int'(battery_avg) - int'(prior_battery_avg);
            if (diff < 0)
                diff = -diff;
            stable = (diff <= int'(tolerance_cfg));
        end
        if (stable)
        begin
            elapsed = item.now_ms - last_take_ms;
            if (elapsed > {16'd0, holdoff_cfg})
            begin
                last_take_ms = item.now_ms;
                take = 1'b1;
            end
        end
        else
        begin
            take = 1'b1;
        end
        if (take)
        begin
            prior_battery_avg = battery_avg;
            prior_valid = 1'b1;
            battery_avg = push_sample(BATTERY_CH, item.battery_sample);
        end
        case (item.charger_status)
            CHG_UNPLUGGED:
            begin
                if (!item.user_active && was_charging)
                begin
                    res.power_off_pulse = 1'b1;
                    hold_on = 1'b0;
                end
                was_charging = 1'b0;
            end
            CHG_CHARGING, CHG_COMPLETE:
            begin
                was_charging = 1'b1;
                hold_on = 1'b1;
            end
            default:
            begin
            end
        endcase
        res.warning_level = WARN_OK;
        if (stable && item.charger_status == CHG_UNPLUGGED)
        begin
            if (battery_avg >= low_cfg)
                res.warning_level = WARN_OK;
            else if (battery_avg >= dead_cfg)
                res.warning_level = WARN_LOW;
            else
                res.warning_level = WARN_DEAD;
        end
        res.temp_average = temp_avg;
        res.battery_average = battery_avg;
        res.battery_stable = stable;
        res.hold_power_on = hold_on;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_cfg = HOLDOFF_RESET;
            low_cfg = LOW_RESET;
            dead_cfg = DEAD_RESET;
            tolerance_cfg = TOLERANCE_RESET;
            for (int ch = 0; ch < 2; ch++)
            begin
                for (int i = 0; i < WINDOW; i++)
                    ring[ch][i] = '0;
                ring_sum[ch] = '0;
                ring_slot[ch] = '0;
            end
            temp_avg = '0;
            battery_avg = '0;
            prior_battery_avg = '0;
            prior_valid = 1'b0;
            last_take_ms = '0;
            was_charging = 1'b0;
            hold_on = 1'b0;
            expected_results.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HOLDOFF:   holdoff_cfg = cfg_data[HOLDOFF_W-1:0];
                    REG_LOW:       low_cfg = cfg_data[THRESH_W-1:0];
                    REG_DEAD:      dead_cfg = cfg_data[THRESH_W-1:0];
                    REG_TOLERANCE: tolerance_cfg = cfg_data[TOL_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result transaction with nothing expected", $realtime);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (out_data !== oldest)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected temp %0d batt %0d stb %0d warn %0d hold %0d off %0d",
                                     oldest.temp_average, oldest.battery_average,
                                     oldest.battery_stable, oldest.warning_level,
                                     oldest.hold_power_on, oldest.power_off_pulse);
                            $display("  actual   temp %0d batt %0d stb %0d warn %0d hold %0d off %0d",
                                     out_data.temp_average, out_data.battery_average,
                                     out_data.battery_stable, out_data.warning_level,
                                     out_data.hold_power_on, out_data.power_off_pulse);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(monitor_pass(in_data));
        end
        results_pending = expected_results.size();
    end

endmodule

// ===== bench/tb_battery_temp_monitor_unit.sv =====
// top of the battery and temperature monitor testbench: clock, reset, stimulus, verdict
// depends on btm_pkg, battery_temp_monitor_unit and battery_temp_monitor_checker
`timescale 1ns / 1ps

module tb_battery_temp_monitor_unit;
    import btm_pkg::*;

    localparam logic [1:0] CHG_RESERVED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    results_pending;

    int                    send_idle_pct;
    int                    ready_stall_pct;
    int unsigned           clock_ms;
    int unsigned           cur_holdoff;
    adc_t                  battery_level;
    logic [1:0]            charger_now;

    battery_temp_monitor_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    battery_temp_monitor_checker u_monitor_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (fail_count),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_battery_temp_monitor_unit failed");
        $finish;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= ready_stall_pct);

    task automatic send_item(input in_item_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_fields(input adc_t temp, input adc_t battery, input logic [1:0] charger,
                               input logic [31:0] ms, input logic active);
        in_item_t item;
        item.temp_sample = temp;
        item.battery_sample = battery;
        item.charger_status = charger;
        item.now_ms = ms;
        item.user_active = active;
        send_item(item);
    endtask

    // hold valid low until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int unsigned holdoff, input int unsigned low,
                              input int unsigned dead, input int unsigned tol);
        write_reg(REG_HOLDOFF, holdoff);
        write_reg(REG_LOW, low);
        write_reg(REG_DEAD, dead);
        write_reg(REG_TOLERANCE, tol);
        cur_holdoff = holdoff;
    endtask

    // mostly a slowly moving battery level and advancing clock, some pure noise
    task automatic next_pass(output in_item_t item);
        int level;
        item.temp_sample = adc_t'($urandom_range(0, 1023));
        item.user_active = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 15)
        begin
            item.battery_sample = adc_t'($urandom_range(0, 1023));
            item.charger_status = 2'($urandom_range(0, 3));
            item.now_ms = $urandom;
        end
        else
        begin
            if ($urandom_range(0, 99) < 3)
                battery_level = adc_t'($urandom_range(0, 1023));
            if ($urandom_range(0, 99) < 5)
                charger_now = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 999) < 3)
                clock_ms = $urandom;
            if ($urandom_range(0, 3) == 0)
                clock_ms = clock_ms + $urandom_range(0, cur_holdoff * 2 + 2);
            else
                clock_ms = clock_ms + $urandom_range(0, cur_holdoff / 8 + 1);
            level = int'(battery_level);
            if ($urandom_range(0, 1) == 1)
                level = level + int'($urandom_range(0, 4)) - 2;
            if (level < 0)
                level = 0;
            if (level > 1023)
                level = 1023;
            item.battery_sample = adc_t'(level);
            item.charger_status = charger_now;
            item.now_ms = clock_ms;
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int count,
                             input bit mid_pause);
        in_item_t item;
        send_idle_pct = idle;
        ready_stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            next_pass(item);
            send_item(item);
            if (mid_pause && i == count / 2)
                drain();
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_HOLDOFF;
        cfg_data = '0;
        send_idle_pct = 0;
        ready_stall_pct = 0;
        clock_ms = 0;
        cur_holdoff = 32'(HOLDOFF_RESET);
        battery_level = 10'd600;
        charger_now = CHG_UNPLUGGED;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, charger transitions, settling to a stable average
        send_fields(10'd0, 10'd0, CHG_UNPLUGGED, 32'd0, 1'b0);
        send_fields(10'd1023, 10'd1023, CHG_RESERVED, 32'hFFFF_FFFF, 1'b1);
        send_fields(10'd512, 10'd0, CHG_CHARGING, 32'd10, 1'b0);
        send_fields(10'd1, 10'd0, CHG_UNPLUGGED, 32'd20, 1'b0);
        send_fields(10'd1022, 10'd0, CHG_COMPLETE, 32'd30, 1'b1);
        send_fields(10'd5, 10'd0, CHG_RESERVED, 32'd40, 1'b0);
        send_fields(10'd700, 10'd0, CHG_UNPLUGGED, 32'd50, 1'b1);
        for (int i = 0; i < 18; i++)
            send_fields(adc_t'($urandom_range(0, 1023)), 10'd300, CHG_UNPLUGGED,
                        32'hFFFF_FF00 + 32'(i * 8), 1'b0);
        // clock wraps past zero while the average is stable
        send_fields(10'd100, 10'd300, CHG_UNPLUGGED, 32'hFFFF_FF00 + 32'(17 * 8 + 150), 1'b0);
        drain();

        run_phase(0, 0, 330, 1'b0);
        set_config(0, 1023, 0, 15);
        run_phase(71, 0, 330, 1'b0);
        set_config(65535, 0, 1023, 0);
        run_phase(0, 71, 330, 1'b0);
        set_config(20, 600, 400, 3);
        run_phase(15, 15, 330, 1'b0);
        set_config(1000, 300, 700, 8);
        run_phase(0, 0, 330, 1'b0);
        set_config(100, 512, 450, 1);
        run_phase(15, 15, 330, 1'b1);

        if (fail_count == 0)
            $display("tb_battery_temp_monitor_unit passed");
        else
            $display("tb_battery_temp_monitor_unit failed");
        $finish;
    end

endmodule
